/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// property a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* hw/rtl/smsd_pkg.sv */
`default_nettype none
package smsd_pkg;
  localparam int MEAN_W = 24;
  localparam int SD_W   = 24;
  localparam int CNT_W  = 11;
  localparam int SSD_W  = 64;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_SINGLE = 2'd1;
  localparam logic [1:0] STAT_DROP   = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // store and sum an accepted item
    logic div_start;  // start a division
    logic div_sel;    // 0: mean division, 1: variance division
    logic take_mean;  // latch mean quotient
    logic rd_issue;   // read address pidx
    logic acc;        // accumulate squared deviation from memory data
    logic acc_clr;
    logic sqrt_start;
    logic take_result;
    logic clr_block;
  } smsd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic pass_end;   // last address issued
    logic single;     // stored count <= 1
  } smsd_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/smsd_ram.sv */
`default_nettype none
module smsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/smsd_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module smsd_div #(
  parameter int NW = 64,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quot
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        q    <= num;
        rem  <= '0;
        d    <= den;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/smsd_sqrt.sv */
`default_nettype none
// Digit-by-digit integer square root, one result bit per cycle.
module smsd_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x_in,
  output logic             done,
  output logic      [31:0] root
);
  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;

  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x    <= x_in;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (x >= res + bitv) begin
          x   <= x - (res + bitv);
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/smsd_datapath.sv */
`default_nettype none
module smsd_datapath #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire smsd_pkg::smsd_cmd_t      cmd,
  output smsd_pkg::smsd_stat_t          stat,
  input  wire logic [SAMPLE_BITS-1:0]   sample,
  output logic      [23:0]              mean,
  output logic      [23:0]              std_dev,
  output logic      [10:0]              sample_count,
  output logic      [1:0]               status
);
  import smsd_pkg::*;
  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int NW   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = SAMPLE_BITS + NW + 1;
  localparam int MFW  = SUMW + 8;   // mean fixed-point magnitude width
  localparam int DW   = SAMPLE_BITS + 9 > MFW ? SAMPLE_BITS + 9 : MFW;
  localparam int DIVD = NW + 1;

  logic [NW-1:0]          cnt;
  logic signed [SUMW-1:0] sum;
  logic                   ovf;
  logic [AW-1:0]          pidx;
  logic [NW-1:0]          pcnt;
  logic signed [MFW:0]    mean_fx;
  logic [SSD_W-1:0]       ssd;
  logic [SAMPLE_BITS-1:0] rdata;
  logic signed [DW:0]     dev;
  logic [DW:0]            adev;
  logic [63:0]            sq;
  logic [64:0]            ssd_sum;
  logic                   full;

  logic [63:0]   div_num;
  logic [DIVD-1:0] div_den;
  logic [63:0]   div_q;
  logic [31:0]   root;
  logic [SUMW-1:0] abs_sum;

  assign full    = (cnt == NW'(MAX_SAMPLES));
  assign abs_sum = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);

  always_comb begin
    if (!cmd.div_sel) begin
      div_num = 64'({abs_sum, 8'd0}) + 64'(cnt >> 1);
      div_den = DIVD'(cnt);
    end else begin
      div_num = ssd;
      div_den = DIVD'(cnt - NW'(1));
    end
  end

  smsd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk(clk), .we(cmd.load && !full), .waddr(cnt[AW-1:0]), .wdata(sample),
    .raddr(pidx), .rdata(rdata)
  );

  smsd_div #(.NW(64), .DW(DIVD)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(div_num), .den(div_den),
    .done(stat.div_done), .quot(div_q)
  );

  smsd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.sqrt_start), .x_in(div_q),
    .done(stat.sqrt_done), .root(root)
  );

  assign stat.pass_end = (pcnt == cnt - NW'(1));
  assign stat.single   = (cnt <= NW'(1));

  assign dev  = (DW+1)'(signed'({rdata, 8'd0})) - (DW+1)'(mean_fx);
  assign adev = dev[DW] ? (DW+1)'(-dev) : (DW+1)'(dev);
  assign ssd_sum = {1'b0, ssd} + {1'b0, sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      sum  <= '0;
      ovf  <= 1'b0;
    end else begin
      if (cmd.clr_block) begin
        cnt <= '0;
        sum <= '0;
        ovf <= 1'b0;
      end else if (cmd.load) begin
        if (full) ovf <= 1'b1;
        else begin
          cnt <= cnt + NW'(1);
          sum <= sum + SUMW'(signed'(sample));
        end
      end
    end
  end

  // square registered before accumulation
  always_ff @(posedge clk) begin
    if (cmd.take_mean)
      mean_fx <= sum[SUMW-1] ? -(MFW+1)'(div_q[MFW-1:0]) : (MFW+1)'(div_q[MFW-1:0]);
    if (cmd.acc_clr) pidx <= '0;
    else if (cmd.rd_issue) pidx <= pidx + AW'(1);
    if (cmd.acc_clr) pcnt <= '0;
    else if (cmd.rd_issue) pcnt <= pcnt + NW'(1);
    sq <= (adev > (DW+1)'(33'hFFFF_FFFF)) ? '1 : 64'(adev[31:0]) * 64'(adev[31:0]);
    if (cmd.acc_clr) ssd <= '0;
    else if (cmd.acc) ssd <= ssd_sum[64] ? '1 : ssd_sum[63:0];
    if (cmd.take_result) begin
      if (mean_fx > (MFW+1)'(8388607)) mean <= 24'h7FFFFF;
      else if (mean_fx < -(MFW+1)'(8388608)) mean <= 24'h800000;
      else mean <= mean_fx[23:0];
      if (stat.single) std_dev <= '0;
      else std_dev <= (root > 32'hFFFFFF) ? 24'hFFFFFF : root[23:0];
      sample_count <= (cnt > NW'(2047)) ? 11'd2047 : 11'(cnt);
      status <= ovf ? STAT_DROP : (stat.single ? STAT_SINGLE : STAT_OK);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/smsd_ctrl.sv */
`default_nettype none
module smsd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_fire,
  input  wire logic                 in_last,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output smsd_pkg::smsd_cmd_t       cmd,
  input  wire smsd_pkg::smsd_stat_t stat
);
  import smsd_pkg::*;
  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_MST   = 10'b0000000010,
    S_MDIV  = 10'b0000000100,
    S_PASS  = 10'b0000001000,
    S_DRAIN = 10'b0000010000,
    S_DRN2  = 10'b0000100000,
    S_VDIV  = 10'b0001000000,
    S_SQRT  = 10'b0010000000,
    S_RES   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   acc_v, acc_v2;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.load = in_fire;
    cmd.acc  = acc_v2;
    unique case (state)
      S_LOAD: if (in_fire && in_last) begin
        state_next = S_MST;
      end
      // sum and count now include the last item
      S_MST: begin
        cmd.div_start = 1'b1;
        state_next    = S_MDIV;
      end
      S_MDIV: if (stat.div_done) begin
        cmd.take_mean = 1'b1;
        cmd.acc_clr   = 1'b1;
        state_next    = S_PASS;
      end
      S_PASS: begin
        cmd.rd_issue = 1'b1;
        if (stat.pass_end) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_DRN2;
      S_DRN2: if (!acc_v2) begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = S_VDIV;
      end
      S_VDIV: begin
        cmd.div_sel = 1'b1;
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: if (stat.sqrt_done) state_next = S_RES;
      S_RES: begin
        cmd.take_result = 1'b1;
        cmd.clr_block   = 1'b1;
        state_next      = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  // read issue -> registered RAM data -> registered square -> accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      acc_v  <= 1'b0;
      acc_v2 <= 1'b0;
    end else begin
      state  <= state_next;
      acc_v  <= cmd.rd_issue;
      acc_v2 <= acc_v;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/sample_mean_and_std_deviation_core.sv */
// Operation: load the block's items, then divide for the mean, run the deviation pass,
//   divide for the variance and take the square root to form the result.
// Blocks: one at a time; no new block is accepted until the result has been taken;
//   the bit-serial divider, square root and second pass take most of a block's time.
// Reset (rst, synchronous, active high) clears counters, sum and controller.
`default_nettype none
`include "assert_macros.svh"
module sample_mean_and_std_deviation_core #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [SAMPLE_BITS-1:0] s_tdata,  // sample
  input  wire logic                   s_tlast,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [63:0]            m_tdata   // mean, std_dev, sample_count, status
);
  import smsd_pkg::*;
  smsd_cmd_t  cmd;
  smsd_stat_t stat;
  logic [23:0] mean, std_dev;
  logic [10:0] sample_count;
  logic [1:0]  status;
  logic        in_fire;

  assign in_fire = s_tvalid && s_tready;
  assign m_tdata = {3'd0, status, sample_count, std_dev, mean};

  smsd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_last(s_tlast), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .stat(stat)
  );

  smsd_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .sample(s_tdata),
    .mean(mean), .std_dev(std_dev), .sample_count(sample_count), .status(status)
  );

  `ASSERT_IMPLIES(a_no_in_busy, clk, rst, m_tvalid, !s_tready)
  `ASSERT_NEXT(a_last_starts, clk, rst, in_fire && s_tlast, !s_tready)
  `ASSERT_IMPLIES(a_status_code, clk, rst, m_tvalid, status <= STAT_DROP)
endmodule
`default_nettype wire
